[rtl/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int KEY_BYTES   = 5;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CAP_W       = 14;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int LEN_W       = 3;
    localparam int HANDLE_W    = 32;
    localparam int ENTRY_W     = 1 + KEY_W + LEN_W + HANDLE_W;

    localparam logic [31:0] HASH_SEED = 32'h1234_5678;
    localparam logic [31:0] HASH_MULT = 32'h5bd1_e995;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;

    typedef struct packed {
        logic                req_type;
        logic [KEY_W-1:0]    key_chars;
        logic [LEN_W-1:0]    key_length;
        logic [HANDLE_W-1:0] record_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] found_handle;
        logic [IDX_W-1:0]    slot_index;
    } t_rsp;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

[rtl/oaht_ram.sv]
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/oaht_hash.sv]
// ----------------------------------------------------------------------------
// oaht_hash
// Multi-cycle key hasher: trims the key, then feeds it byte by byte through the
// multiply-xorshift home hash and the polynomial step hash. The home slot
// comes from a serial restoring remainder by the capacity. The step is
// reduced by 97 through folding and a reciprocal multiply, then by the
// capacity through a short serial remainder.
// ----------------------------------------------------------------------------
module oaht_hash
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [CAP_W-1:0]  i_cap,
    output logic              o_done,
    output logic [KEY_W-1:0]  o_key,
    output logic [LEN_W-1:0]  o_len,
    output logic [IDX_W-1:0]  o_home,
    output logic [6:0]        o_step
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_XOR  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_pos;
    logic [31:0]      r_h, r_p;
    logic [5:0]       r_bit;
    logic [14:0]      r_rem_h;
    logic [6:0]       r_rem_p;
    logic [21:0]      r_fold;
    logic [9:0]       r_quo;
    logic [6:0]       r_sv;
    logic [6:0]       r_rem_s;

    logic [KEY_W-1:0] w_key;
    logic [LEN_W-1:0] w_len;
    logic [7:0]       w_byte;
    logic [31:0]      w_mul;
    logic [31:0]      w_p;
    logic [14:0]      w_sh_h;
    logic [34:0]      w_prod;
    logic [16:0]      w_rem;
    logic [7:0]       w_sh_s;
    logic [7:0]       w_dif;
    logic [6:0]       w_red_s;
    logic             w_stop;

    always_comb begin
        logic [LEN_W-1:0] lim;
        w_key = '0;
        w_len = '0;
        w_stop = 1'b0;
        lim = (i_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : i_len;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (!w_stop && LEN_W'(i) < lim && i_key[KEY_W-1-8*i -: 8] != 8'd0) begin
                w_key[KEY_W-1-8*i -: 8] = i_key[KEY_W-1-8*i -: 8];
                w_len = LEN_W'(i + 1);
            end else begin
                w_stop = 1'b1;
            end
        end
    end

    assign w_byte  = r_key[KEY_W-1 -: 8];
    assign w_mul   = (r_h ^ {24'd0, w_byte}) * HASH_MULT;
    assign w_p     = (r_p << 5) - r_p + {24'd0, w_byte};
    assign w_sh_h  = {r_rem_h[13:0], r_h[r_bit[4:0]]};
    assign w_prod  = {18'd0, r_fold[16:0]} * 35'd172961;
    assign w_rem   = r_fold[16:0] - {7'd0, r_quo} * 17'd97;
    assign w_sh_s  = {r_rem_s, r_sv[6]};
    assign w_dif   = w_sh_s - i_cap[7:0];
    assign w_red_s = (CAP_W'(w_sh_s) >= i_cap) ? w_dif[6:0] : w_sh_s[6:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL:  n_state = (r_pos == r_len) ? S_MOD : S_XOR;
            S_XOR:  n_state = S_MUL;
            S_MOD:  if (r_bit == 6'd0) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_key   <= w_key;
                o_key   <= w_key;
                r_len   <= w_len;
                r_pos   <= '0;
                r_h     <= HASH_SEED;
                r_p     <= HASH_SEED;
                r_bit   <= 6'd31;
                r_rem_h <= '0;
                r_rem_p <= '0;
            end
            S_MUL: begin
                if (r_pos != r_len) begin
                    r_h   <= w_mul;
                    r_p   <= w_p;
                    r_key <= r_key << 8;
                    r_pos <= r_pos + LEN_W'(1);
                end
            end
            S_XOR: begin
                r_h <= r_h ^ (r_h >> 15);
            end
            S_MOD: begin
                r_rem_h <= (w_sh_h >= {1'b0, i_cap}) ? w_sh_h - {1'b0, i_cap} : w_sh_h;
                r_bit   <= r_bit - 6'd1;
                case (r_bit)
                    6'd31: r_fold <= {6'd0, r_p[31:16]} * 22'd61 + {6'd0, r_p[15:0]};
                    6'd30: r_fold <= {5'd0, {11'd0, r_fold[21:16]} * 17'd61 +
                                     {1'b0, r_fold[15:0]}};
                    6'd29: r_quo  <= w_prod[33:24];
                    6'd28: r_rem_p <= w_rem[6:0];
                    6'd27: begin
                        r_sv    <= r_rem_p + 7'd1;
                        r_rem_s <= '0;
                    end
                    default: begin
                        if (r_bit <= 6'd26 && r_bit >= 6'd20) begin
                            r_rem_s <= w_red_s;
                            r_sv    <= r_sv << 1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == S_DONE);
    assign o_len  = r_len;
    assign o_home = IDX_W'(r_rem_h);
    assign o_step = r_rem_s;

endmodule

[rtl/oaht_probe.sv]
// ----------------------------------------------------------------------------
// oaht_probe
// Probe sequencer: walks the slot memory from the home slot, one read per
// probe, writes the new entry on insert and clears the slots in the clearing pass.
// ----------------------------------------------------------------------------
module oaht_probe
    import oaht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic                i_req_type,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [LEN_W-1:0]    i_len,
    input  logic [IDX_W-1:0]    i_home,
    input  logic [6:0]          i_step,
    input  logic [CAP_W-1:0]    i_cap,
    input  logic                i_mode,
    input  logic                i_clr_busy,
    input  logic [IDX_W-1:0]    i_clr_addr,
    output logic                o_done,
    output t_rsp                o_rsp
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_READ = 2'd1;
    localparam logic [1:0] P_EVAL = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, r_start;
    logic [CAP_W-1:0] r_probes;
    logic [CAP_W-1:0] r_count;
    logic             r_done;
    t_rsp             r_rsp;

    t_entry           w_rd, w_wd;
    logic             w_we;
    logic [IDX_W-1:0] w_addr;
    logic [CAP_W:0]   w_sum;
    logic [IDX_W-1:0] w_next;
    logic             w_full;

    assign w_sum  = {1'b0, {1'b0, r_idx} + CAP_W'(i_mode ? i_step : 7'd1)};
    assign w_next = IDX_W'((w_sum >= {1'b0, i_cap}) ? w_sum - {1'b0, i_cap} : w_sum);
    assign w_full = ({1'b0, r_count} >= ({1'b0, i_cap} - 15'd1));

    assign w_wd.valid  = !i_clr_busy;
    assign w_wd.key    = i_key;
    assign w_wd.len    = i_len;
    assign w_wd.handle = i_handle;
    assign w_we   = i_clr_busy || (r_state == P_EVAL && i_req_type == REQ_INSERT &&
                    !w_rd.valid);
    assign w_addr = i_clr_busy ? i_clr_addr : r_idx;

    oaht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wd),
        .o_rdata(w_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            P_IDLE: begin
                if (i_go) begin
                    n_state = (i_req_type == REQ_INSERT && w_full) ? P_IDLE : P_READ;
                end
            end
            P_READ: n_state = P_EVAL;
            P_EVAL: begin
                if (!w_rd.valid || (i_req_type == REQ_LOOKUP &&
                    w_rd.len == i_len && w_rd.key == i_key) ||
                    r_probes + CAP_W'(1) >= i_cap ||
                    (i_req_type == REQ_LOOKUP && w_next == r_start)) begin
                    n_state = P_IDLE;
                end else begin
                    n_state = P_READ;
                end
            end
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == P_IDLE && i_go && i_req_type == REQ_INSERT && w_full) begin
                r_done <= 1'b1;
            end
            if (r_state == P_EVAL && n_state == P_IDLE) begin
                r_done <= 1'b1;
            end
            if (w_we && !i_clr_busy) begin
                r_count <= r_count + CAP_W'(1);
            end
        end
        case (r_state)
            P_IDLE: begin
                r_idx    <= i_home;
                r_start  <= i_home;
                r_probes <= '0;
                r_rsp    <= '{status: ST_FULL, found_handle: '0, slot_index: '0};
            end
            P_EVAL: begin
                r_idx    <= w_next;
                r_probes <= r_probes + CAP_W'(1);
                if (!w_rd.valid) begin
                    if (i_req_type == REQ_INSERT) begin
                        r_rsp <= '{status: ST_INSERTED, found_handle: '0,
                                   slot_index: r_idx};
                    end else begin
                        r_rsp <= '{status: ST_NOT_FOUND, found_handle: '0,
                                   slot_index: '0};
                    end
                end else if (i_req_type == REQ_LOOKUP && w_rd.len == i_len &&
                             w_rd.key == i_key) begin
                    r_rsp <= '{status: ST_FOUND, found_handle: w_rd.handle,
                               slot_index: r_idx};
                end else if (i_req_type == REQ_LOOKUP) begin
                    r_rsp <= '{status: ST_NOT_FOUND, found_handle: '0,
                               slot_index: '0};
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

[rtl/open_addressing_hash_table.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Hash table of short keys and record handles, with linear or double-hash
// probing over one slot memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  request  in         i_valid/o_ready  t_req
//  result   out        o_valid/i_ready  t_rsp
//  config   in         APB              table_capacity, probe_mode
//
//  A transaction hashes the key a byte at a time, works out the serial
//  remainders, then probes the single-port slot memory with a read and an
//  evaluation per probe. A refused insert ends before any probe is made.
//  After reset a clearing pass over all 8192 slots runs before the first request.
//  One request is in flight at a time; a result waits in its register
//  until taken, and no request is accepted while it waits.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0] r_cap_reg;
    logic             r_mode;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_busy;
    logic             r_hash_go, r_probe_go;
    t_req             r_req;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [CAP_W-1:0] w_cap;
    logic             w_hdone, w_pdone;
    logic [KEY_W-1:0] w_key;
    logic [LEN_W-1:0] w_len;
    logic [IDX_W-1:0] w_home;
    logic [6:0]       w_step;
    t_rsp             w_rsp;
    logic             w_wr;

    assign w_cap = (r_cap_reg < CAP_W'(2)) ? CAP_W'(2) :
                   (r_cap_reg > CAP_W'(TABLE_DEPTH)) ? CAP_W'(TABLE_DEPTH) : r_cap_reg;
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_MODE[0]) ? {31'd0, r_mode} : {18'd0, r_cap_reg};
    assign o_ready = !r_busy && !r_clr_busy && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg   <= CAP_W'(TABLE_DEPTH);
            r_mode      <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_hash_go   <= 1'b0;
            r_probe_go  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr && paddr == {REG_CAPACITY[0], 2'b00}) r_cap_reg <= pwdata[CAP_W-1:0];
            if (w_wr && paddr == {REG_MODE[0], 2'b00})     r_mode    <= pwdata[0];
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) r_clr_busy <= 1'b0;
            end
            r_hash_go  <= i_valid && o_ready;
            r_probe_go <= w_hdone;
            if (i_valid && o_ready) r_busy <= 1'b1;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            if (w_pdone && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_busy      <= 1'b0;
            end
        end
        if (i_valid && o_ready) r_req <= i_req;
        if (w_pdone && !r_out_valid) r_out <= w_rsp;
    end

    oaht_hash u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_hash_go),
        .i_key  (r_req.key_chars),
        .i_len  (r_req.key_length),
        .i_cap  (w_cap),
        .o_done (w_hdone),
        .o_key  (w_key),
        .o_len  (w_len),
        .o_home (w_home),
        .o_step (w_step)
    );

    oaht_probe u_probe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_probe_go),
        .i_req_type(r_req.req_type),
        .i_handle  (r_req.record_handle),
        .i_key     (w_key),
        .i_len     (w_len),
        .i_home    (w_home),
        .i_step    (w_step),
        .i_cap     (w_cap),
        .i_mode    (r_mode),
        .i_clr_busy(r_clr_busy),
        .i_clr_addr(r_clr_addr),
        .o_done    (w_pdone),
        .o_rsp     (w_rsp)
    );

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("request taken while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid || $past(o_valid))
        else $error("result without work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_rsp))
        else $error("result dropped");

endmodule

[verif/oaht_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oaht_checker
// Watches the request, result and APB channels of the hash table. It keeps
// its own copy of the slots, the count and the registers, works out the
// result of each accepted request and compares it with the results taken.
// ----------------------------------------------------------------------------
module oaht_checker
    import oaht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  t_req        i_req,
    input  logic        o_valid,
    input  logic        i_ready,
    input  t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    logic [CAP_W-1:0]    capacity_reg;
    logic                double_mode;
    logic                slot_used [TABLE_DEPTH];
    logic [KEY_W-1:0]    slot_key [TABLE_DEPTH];
    logic [LEN_W-1:0]    slot_len [TABLE_DEPTH];
    logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH];
    int unsigned         stored_count;
    t_rsp                awaited_results [$];

    function automatic t_rsp table_outcome(t_req rq);
        t_rsp             rsp;
        logic [KEY_W-1:0] key;
        logic [31:0]      home;
        logic [31:0]      poly;
        logic [7:0]       ch;
        int unsigned      len;
        int unsigned      n;
        int unsigned      cap;
        int unsigned      start;
        int unsigned      step;
        int unsigned      idx;
        int unsigned      probes;
        rsp = '0;
        key = '0;
        n = 0;
        len = (rq.key_length > KEY_BYTES) ? KEY_BYTES : rq.key_length;
        while (n < len && rq.key_chars[KEY_W-1-8*n -: 8] != 8'd0) begin
            key[KEY_W-1-8*n -: 8] = rq.key_chars[KEY_W-1-8*n -: 8];
            n++;
        end
        home = HASH_SEED;
        poly = HASH_SEED;
        for (int i = 0; i < n; i++) begin
            ch = key[KEY_W-1-8*i -: 8];
            home = home ^ {24'd0, ch};
            home = home * HASH_MULT;
            home = home ^ (home >> 15);
            poly = poly * 32'd31 + {24'd0, ch};
        end
        cap = capacity_reg;
        if (cap < 2) cap = 2;
        if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
        start = home % cap;
        step = double_mode ? (poly % 32'd97) + 1 : 1;
        idx = start;
        if (rq.req_type == REQ_INSERT) begin
            rsp.status = ST_FULL;
            if (stored_count < cap - 1) begin
                for (probes = 0; probes < cap; probes++) begin
                    if (!slot_used[idx]) begin
                        slot_used[idx] = 1'b1;
                        slot_key[idx] = key;
                        slot_len[idx] = LEN_W'(n);
                        slot_handle[idx] = rq.record_handle;
                        stored_count++;
                        rsp.status = ST_INSERTED;
                        rsp.slot_index = IDX_W'(idx);
                        break;
                    end
                    idx = (idx + step) % cap;
                end
            end
        end else begin
            rsp.status = ST_NOT_FOUND;
            for (probes = 0; probes < cap && slot_used[idx]; probes++) begin
                if (slot_len[idx] == n && slot_key[idx] == key) begin
                    rsp.status = ST_FOUND;
                    rsp.found_handle = slot_handle[idx];
                    rsp.slot_index = IDX_W'(idx);
                    break;
                end
                idx = (idx + step) % cap;
                if (idx == start) break;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            capacity_reg <= CAP_W'(TABLE_DEPTH);
            double_mode <= 1'b0;
            stored_count = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2:2] == REG_CAPACITY[0:0]) capacity_reg <= pwdata[CAP_W-1:0];
                else double_mode <= pwdata[0];
            end
            if (i_valid && o_ready) awaited_results.push_back(table_outcome(i_req));
            if (o_valid && i_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", o_rsp.status);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (o_rsp.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_rsp.status);
                        fail_count++;
                    end
                    if (o_rsp.found_handle !== want.found_handle) begin
                        $error("found_handle expected %0h got %0h",
                               want.found_handle, o_rsp.found_handle);
                        fail_count++;
                    end
                    if (o_rsp.slot_index !== want.slot_index) begin
                        $error("slot_index expected %0d got %0d",
                               want.slot_index, o_rsp.slot_index);
                        fail_count++;
                    end
                end
            end
        end
        pending = awaited_results.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
    end

endmodule

[verif/open_addressing_hash_table_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_test
// Drives directed and random inserts and lookups through the hash table over
// a series of capacities and probe modes, with random gaps on both channels.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_test;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int N_PHASES    = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_req        i_req;
    logic        o_valid;
    logic        i_ready;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          checked;
    int          cycles;
    int          sent;
    logic        calm;
    logic [KEY_W-1:0] pool_key [32];
    logic [LEN_W-1:0] pool_len [32];

    open_addressing_hash_table dut (.*);

    oaht_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 28);
    end

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * index);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_request(input t_req rq);
        if (!calm && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic kind, input logic [KEY_W-1:0] chars,
                               input logic [LEN_W-1:0] len, input logic [31:0] handle);
        t_req rq;
        rq.req_type = kind;
        rq.key_chars = chars;
        rq.key_length = len;
        rq.record_handle = handle;
        send_request(rq);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic fill_pool;
        for (int i = 0; i < 32; i++) begin
            pool_key[i] = KEY_W'({$urandom, $urandom});
            if ($urandom_range(3) == 0)
                pool_key[i][KEY_W-1-8*$urandom_range(4) -: 8] = 8'd0;
            pool_len[i] = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(7))
                                                  : LEN_W'($urandom_range(1, 5));
        end
    endtask

    function automatic t_req random_request();
        t_req rq;
        int   p;
        rq.req_type = $urandom_range(1) ? REQ_LOOKUP : REQ_INSERT;
        rq.key_chars = KEY_W'({$urandom, $urandom});
        rq.key_length = LEN_W'($urandom_range(7));
        rq.record_handle = $urandom;
        if ($urandom_range(99) < 75) begin
            p = $urandom_range(31);
            for (int i = 0; i < KEY_BYTES; i++)
                if (i < pool_len[p])
                    rq.key_chars[KEY_W-1-8*i -: 8] = pool_key[p][KEY_W-1-8*i -: 8];
            rq.key_length = pool_len[p];
        end
        return rq;
    endfunction

    initial begin
        int caps [N_PHASES] = '{16, 2, 0, 1, 97, 200, 256, 16383, 8192, 40, 13};
        int modes [N_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
        int counts [N_PHASES] = '{150, 40, 40, 40, 250, 300, 300, 250, 230, 220, 30};
        cycles = 0;
        sent = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fields(REQ_INSERT, 40'h41_42_43_44_45, 3'd5, 32'h0000_0001);
        send_fields(REQ_LOOKUP, 40'h41_42_43_44_45, 3'd5, 32'hdead_beef);
        send_fields(REQ_LOOKUP, 40'h41_42_43_44_45, 3'd4, 32'h0);
        send_fields(REQ_INSERT, 40'h41_42_43_44_45, 3'd5, 32'h0000_0002);
        send_fields(REQ_LOOKUP, 40'h41_42_43_44_ff, 3'd5, 32'h0);
        send_fields(REQ_INSERT, 40'h00_00_00_00_00, 3'd0, 32'hffff_ffff);
        send_fields(REQ_LOOKUP, 40'hff_ff_ff_ff_ff, 3'd0, 32'h0);
        send_fields(REQ_LOOKUP, 40'h00_ff_ff_ff_ff, 3'd3, 32'h0);
        send_fields(REQ_INSERT, 40'h41_00_42_43_44, 3'd5, 32'h0000_0003);
        send_fields(REQ_LOOKUP, 40'h41_ff_ff_ff_ff, 3'd1, 32'h0);
        send_fields(REQ_INSERT, 40'hff_ff_ff_ff_ff, 3'd7, 32'h8000_0000);
        send_fields(REQ_LOOKUP, 40'hff_ff_ff_ff_ff, 3'd5, 32'h0);
        send_fields(REQ_LOOKUP, 40'hff_ff_ff_ff_ff, 3'd6, 32'h0);
        send_fields(REQ_INSERT, 40'h80_81_fe_7f_01, 3'd4, 32'h0);
        send_fields(REQ_LOOKUP, 40'h80_81_fe_7f_00, 3'd5, 32'h0);
        send_fields(REQ_LOOKUP, 40'h7f_7f_7f_7f_7f, 3'd2, 32'h0);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(REG_CAPACITY, 32'(caps[ph]));
            write_reg(REG_MODE, 32'(modes[ph]));
            fill_pool();
            calm = (ph == 5);
            for (int k = 0; k < counts[ph]; k++) begin
                send_request(random_request());
                if (ph == 4 && k == 100) drain();
            end
            drain();
        end
        calm = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d inserts and lookups over %0d capacity and probe settings;",
                 sent, N_PHASES + 1);
        $display("%0d results were compared field by field.", checked);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_hash.sv
rtl/oaht_probe.sv
rtl/open_addressing_hash_table.sv
verif/oaht_checker.sv
verif/open_addressing_hash_table_test.sv
